/* rtl/tsq_pkg.sv */
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and codes for the shootdown request queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   typedef enum logic [2:0] {
      OP_ENQ_PAGE  = 3'd0,
      OP_ENQ_ALL   = 3'd1,
      OP_TAKE      = 3'd2,
      OP_ACK       = 3'd3,
      OP_PEND_QRY  = 3'd4,
      OP_ACK_QRY   = 3'd5
   } opcode_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd1;
   localparam logic [1:0] ST_NO_REQ    = 2'd2;
   localparam logic [1:0] ST_ACK_FULL  = 2'd3;

   typedef struct packed {
      logic [31:0] seq;
      logic [63:0] addr;
      logic [5:0]  src;
      logic [5:0]  tgt;
      logic        scope_all;
      logic        has_ctx;
      logic [11:0] ctx;
   } entry_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [5:0]  src_core;
      logic [5:0]  tgt_core;
      logic [63:0] page_addr;
      logic        has_context;
      logic [11:0] ctx_id;
      logic [31:0] ack_sequence;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        answer_flag;
      logic [31:0] out_sequence;
      logic [5:0]  out_src_core;
      logic [5:0]  out_tgt_core;
      logic        out_scope_all;
      logic [63:0] out_address;
      logic        out_has_context;
      logic [11:0] out_ctx_id;
      logic [4:0]  pending_total;
      logic [6:0]  acknowledged_total;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_OUT
   } state_type;

endpackage

/* rtl/tsq_if.sv */
// ----------------------------------------------------------------------------
// tsq_req_if / tsq_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface tsq_req_if import tsq_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tsq_rsp_if import tsq_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/tsq_queue_cell.sv */
// ----------------------------------------------------------------------------
// tsq_queue_cell
// One queue slot: holds an entry, loads a new one or shifts in its neighbor.
// ----------------------------------------------------------------------------
module tsq_queue_cell
   import tsq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  entry_type load_entry,
   input  logic      shift,
   input  entry_type next_entry,
   input  logic      next_valid,
   input  logic      occupy,
   input  logic [5:0] match_tgt,
   output entry_type entry,
   output logic      valid,
   output logic      hit
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (load) begin
         entry_in = load_entry;
         valid_in = 1'b1;
      end else if (shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (occupy) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign hit   = valid_ff && (entry_ff.tgt == match_tgt);

endmodule

/* rtl/tsq_ack_cell.sv */
// ----------------------------------------------------------------------------
// tsq_ack_cell
// One acknowledge table slot with its own compare.
// ----------------------------------------------------------------------------
module tsq_ack_cell
   import tsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [31:0] load_seq,
   input  logic [31:0] match_seq,
   output logic        valid,
   output logic        hit
);

   logic [31:0] seq_ff;
   logic        valid_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         seq_ff <= load_seq;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end
   end

   assign valid = valid_ff;
   assign hit   = valid_ff && (seq_ff == match_seq);

endmodule

/* rtl/tlb_shootdown_request_queue_unit.sv */
// ----------------------------------------------------------------------------
// tlb_shootdown_request_queue_unit
// Ordered shootdown request queue with acknowledge table, built as cell rows.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | opcode, cores, address, context, ack sequence
//  rsp     | out | status, answer, request fields, totals
//
//  A request passes in turn through accept, execute and output: the accept
//  cycle registers the beat, the execute cycle lets every cell compare in
//  parallel, picks the first hit and updates the cells, and the response beat
//  then leaves the output register. The next request is taken in the cycle
//  after the response beat; a response stall holds it off. Reset is synchronous
//  and empties both rows.
// ----------------------------------------------------------------------------
module tlb_shootdown_request_queue_unit
   import tsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ACK_DEPTH   = 64
)(
   input logic clock,
   input logic reset,
   tsq_req_if.sink   req,
   tsq_rsp_if.source rsp
);

   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(ACK_DEPTH + 1);

   state_type   state_ff, state_in;
   req_type     cmd_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic [QW-1:0] pfill_ff, pfill_in;
   logic [AW-1:0] afill_ff, afill_in;

   entry_type q_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] q_valid, q_hit, q_load, q_shift;
   logic [ACK_DEPTH-1:0]   a_valid, a_hit, a_load;
   entry_type new_entry, taken;
   logic [QUEUE_DEPTH-1:0] first_hit, at_or_after;
   logic any_q_hit, any_a_hit, do_exec;

   assign new_entry.seq       = next_seq_ff;
   assign new_entry.addr      = (cmd_ff.opcode == OP_ENQ_PAGE) ? cmd_ff.page_addr : '0;
   assign new_entry.src       = cmd_ff.src_core;
   assign new_entry.tgt       = cmd_ff.tgt_core;
   assign new_entry.scope_all = cmd_ff.opcode[0];
   assign new_entry.has_ctx   = cmd_ff.has_context;
   assign new_entry.ctx       = cmd_ff.has_context ? cmd_ff.ctx_id : '0;

   // one-hot first hit and thermometer mask from it
   assign first_hit   = q_hit & (~q_hit + 1'b1);
   assign at_or_after = ~(first_hit - 1'b1) & ~'0;
   assign any_q_hit   = |q_hit;
   assign any_a_hit   = |a_hit;
   assign do_exec     = (state_ff == S_EXEC);

   always_comb begin
      taken = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (first_hit[i]) taken = q_entry[i];
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_q
         entry_type nxt;
         logic      nxt_v;
         if (g == QUEUE_DEPTH - 1) begin : g_end
            assign nxt   = q_entry[g];
            assign nxt_v = 1'b0;
         end else begin : g_mid
            assign nxt   = q_entry[g+1];
            assign nxt_v = q_valid[g+1];
         end
         assign q_load[g]  = do_exec && (cmd_ff.opcode == OP_ENQ_PAGE ||
                              cmd_ff.opcode == OP_ENQ_ALL) &&
                              (pfill_ff == QW'(g));
         assign q_shift[g] = do_exec && (cmd_ff.opcode == OP_TAKE) && at_or_after[g];
         tsq_queue_cell u_cell (
            .clock(clock), .reset(reset),
            .load(q_load[g]), .load_entry(new_entry),
            .shift(q_shift[g]), .next_entry(nxt), .next_valid(nxt_v),
            .occupy(1'b0), .match_tgt(cmd_ff.tgt_core),
            .entry(q_entry[g]), .valid(q_valid[g]), .hit(q_hit[g])
         );
      end
      for (g = 0; g < ACK_DEPTH; g++) begin : g_a
         assign a_load[g] = do_exec && (cmd_ff.opcode == OP_ACK) && !any_a_hit &&
                            (afill_ff == AW'(g));
         tsq_ack_cell u_ack (
            .clock(clock), .reset(reset),
            .load(a_load[g]), .load_seq(cmd_ff.ack_sequence),
            .match_seq(cmd_ff.ack_sequence),
            .valid(a_valid[g]), .hit(a_hit[g])
         );
      end
   endgenerate

   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      rsp_in      = rsp_ff;
      next_seq_in = next_seq_ff;
      pfill_in    = pfill_ff;
      afill_in    = afill_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) state_in = S_EXEC;
         S_EXEC: begin
            rsp_in   = '0;
            state_in = S_OUT;
            case (cmd_ff.opcode)
               OP_ENQ_PAGE, OP_ENQ_ALL: begin
                  if (pfill_ff == QW'(QUEUE_DEPTH)) begin
                     rsp_in.status = ST_QUEUE_FULL;
                  end else begin
                     rsp_in.out_sequence    = new_entry.seq;
                     rsp_in.out_src_core    = new_entry.src;
                     rsp_in.out_tgt_core    = new_entry.tgt;
                     rsp_in.out_scope_all   = new_entry.scope_all;
                     rsp_in.out_address     = new_entry.addr;
                     rsp_in.out_has_context = new_entry.has_ctx;
                     rsp_in.out_ctx_id      = new_entry.ctx;
                     pfill_in    = pfill_ff + 1'b1;
                     next_seq_in = next_seq_ff + 32'd1;
                  end
               end
               OP_TAKE: begin
                  if (any_q_hit) begin
                     rsp_in.answer_flag     = 1'b1;
                     rsp_in.out_sequence    = taken.seq;
                     rsp_in.out_src_core    = taken.src;
                     rsp_in.out_tgt_core    = taken.tgt;
                     rsp_in.out_scope_all   = taken.scope_all;
                     rsp_in.out_address     = taken.addr;
                     rsp_in.out_has_context = taken.has_ctx;
                     rsp_in.out_ctx_id      = taken.ctx;
                     pfill_in = pfill_ff - 1'b1;
                  end else begin
                     rsp_in.status = ST_NO_REQ;
                  end
               end
               OP_ACK: begin
                  if (!any_a_hit) begin
                     if (afill_ff == AW'(ACK_DEPTH)) rsp_in.status = ST_ACK_FULL;
                     else afill_in = afill_ff + 1'b1;
                  end
               end
               OP_PEND_QRY: rsp_in.answer_flag = any_q_hit;
               OP_ACK_QRY:  rsp_in.answer_flag = any_a_hit;
               default: ;
            endcase
            rsp_in.pending_total      = 5'(pfill_in);
            rsp_in.acknowledged_total = 7'(afill_in);
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) cmd_ff <= req.data;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff    <= S_IDLE;
         next_seq_ff <= '0;
         pfill_ff    <= '0;
         afill_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         next_seq_ff <= next_seq_in;
         pfill_ff    <= pfill_in;
         afill_ff    <= afill_in;
      end
   end

`ifndef SYNTHESIS
   a_qfill: assert property (@(posedge clock) disable iff (reset)
      $countones(q_valid) == int'(pfill_ff)) else $error("queue fill mismatch");
   a_afill: assert property (@(posedge clock) disable iff (reset)
      $countones(a_valid) == int'(afill_ff)) else $error("ack fill mismatch");
   a_ahit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(a_hit)) else $error("duplicate ack entry");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp_ff)) else $error("response changed");
`endif

endmodule
